// ===== rtl/mcss_pkg.sv =====
`default_nettype none
package mcss_pkg;

	localparam int MAX_STATES = 16;
	localparam int PROB_BITS  = 16;
	localparam int SUM_BITS   = PROB_BITS + 4;
	localparam int IDX_W      = $clog2(MAX_STATES);
	localparam int CNT_W      = $clog2(MAX_STATES + 1);
	localparam int CFG_W      = 5;
	// matrix rows first, initial distribution as one extra row at the end
	localparam int MEM_DEPTH  = (MAX_STATES + 1) * MAX_STATES;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int INIT_BASE  = MAX_STATES * MAX_STATES;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_WRITE_INIT   = 2'd0,
		OP_WRITE_MATRIX = 2'd1,
		OP_STEP         = 2'd2,
		OP_RESTART      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_STEP,
		CMD_RESTART
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [ADDR_W-1:0]     addr;
		logic [PROB_BITS-1:0]  value;  // table value for a write, random value for a step
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic              from_initial;
		logic [IDX_W-1:0]  next_state;
	} result_t;

	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/mcss_front.sv =====
`default_nettype none
module mcss_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,
	input  logic [1:0]                    s_tuser,
	output logic                          push,
	output mcss_pkg::cmd_t                push_cmd,
	input  logic                          push_ready
);
	import mcss_pkg::*;

	logic                  cmd_v_q;
	cmd_t                  cmd_q;
	cmd_t                  cmd_d;
	op_t                   op;
	logic [IDX_W-1:0]      row;
	logic [IDX_W-1:0]      column;
	logic [PROB_BITS-1:0]  probability;
	logic [PROB_BITS-1:0]  random_fraction;

	assign op              = op_t'(s_tuser);
	assign row             = s_tdata[3:0];
	assign column          = s_tdata[7:4];
	assign probability     = s_tdata[23:8];
	assign random_fraction = s_tdata[39:24];

	assign s_tready = !cmd_v_q || push_ready;
	assign push     = cmd_v_q;
	assign push_cmd = cmd_q;

	always_comb begin
		cmd_d.kind  = CMD_WRITE;
		cmd_d.addr  = ADDR_W'(row) * ADDR_W'(MAX_STATES) + ADDR_W'(column);
		cmd_d.value = probability;
		case (op)
			OP_WRITE_INIT: begin
				cmd_d.addr = ADDR_W'(INIT_BASE) + ADDR_W'(column);
			end
			OP_WRITE_MATRIX: begin
				cmd_d.kind = CMD_WRITE;
			end
			OP_STEP: begin
				cmd_d.kind  = CMD_STEP;
				cmd_d.value = random_fraction;
			end
			OP_RESTART: begin
				cmd_d.kind = CMD_RESTART;
			end
			default: begin
				cmd_d.kind = CMD_RESTART;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			cmd_v_q <= 1'b1;
		end else if (push_ready) begin
			cmd_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mcss_queue.sv =====
`default_nettype none
module mcss_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcss_pkg::cmd_t  push_cmd,
	output logic            push_ready,
	output logic            pop_valid,
	output mcss_pkg::cmd_t  pop_cmd,
	input  logic            pop
);
	import mcss_pkg::*;

	cmd_t                 entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mcss_back.sv =====
`default_nettype none
module mcss_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mcss_pkg::CFG_W-1:0]   num_states,
	input  logic                         pop_valid,
	input  mcss_pkg::cmd_t               pop_cmd,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output mcss_pkg::result_t            m_result
);
	import mcss_pkg::*;

	logic [PROB_BITS-1:0]  mem [MEM_DEPTH];
	logic [PROB_BITS-1:0]  rd_data_s1;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [IDX_W-1:0]      cur_state_q;
	logic                  started_q;
	logic                  init_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      iss_q;
	logic [IDX_W-1:0]      acc_idx_q;
	logic                  data_v_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [PROB_BITS-1:0]  rnd_q;
	logic [ADDR_W-1:0]     base_q;
	logic                  m_valid_q;
	result_t               res_q;

	logic                  out_free;
	logic [CNT_W-1:0]      n_in;
	logic                  mem_we;
	logic                  start;
	logic                  clr_started;
	logic                  finish;
	result_t               res_d;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [SUM_BITS:0]     sum_add;
	logic [SUM_BITS-1:0]   sum_sat;
	logic                  hit_now;
	logic                  last_now;

	assign out_free = !m_valid_q || m_tready;
	assign n_in     = (CNT_W'(num_states) > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES)
	                                                            : CNT_W'(num_states);
	assign rd_en    = (state_q == BK_WALK) && (iss_q < n_q);
	assign rd_addr  = base_q + ADDR_W'(iss_q);

	// saturating running sum of the row so far
	assign sum_add  = {1'b0, sum_q} + (SUM_BITS + 1)'(rd_data_s1);
	assign sum_sat  = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
	assign hit_now  = data_v_q && (sum_sat > SUM_BITS'(rnd_q));
	assign last_now = data_v_q && ((CNT_W'(acc_idx_q) + 1'b1) == n_q);

	assign m_tvalid = m_valid_q;
	assign m_result = res_q;

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		mem_we      = 1'b0;
		start       = 1'b0;
		clr_started = 1'b0;
		finish      = 1'b0;
		res_d.next_state   = cur_state_q;
		res_d.from_initial = init_q;
		res_d.found        = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					case (pop_cmd.kind)
						CMD_WRITE: begin
							pop    = 1'b1;
							mem_we = 1'b1;
						end
						CMD_RESTART: begin
							pop         = 1'b1;
							clr_started = 1'b1;
						end
						CMD_STEP: begin
							// wait for the output word to drain so the result has room
							if (out_free) begin
								pop   = 1'b1;
								start = 1'b1;
								if (n_in == '0) begin
									finish             = 1'b1;
									res_d.from_initial = !started_q;
								end else begin
									state_d = BK_WALK;
								end
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_WALK: begin
				if (hit_now || last_now) begin
					finish      = 1'b1;
					res_d.found = hit_now;
					if (hit_now) begin
						res_d.next_state = acc_idx_q;
					end
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cur_state_q <= '0;
			started_q   <= 1'b0;
			init_q      <= 1'b0;
			n_q         <= '0;
			iss_q       <= '0;
			data_v_q    <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_started) begin
				started_q <= 1'b0;
			end
			if (start) begin
				init_q    <= !started_q;
				started_q <= 1'b1;
				n_q       <= n_in;
				iss_q     <= '0;
				data_v_q  <= 1'b0;
			end else if (state_q == BK_WALK) begin
				data_v_q <= rd_en && !finish;
				if (rd_en) begin
					iss_q <= iss_q + 1'b1;
				end
			end
			if (finish && res_d.found) begin
				cur_state_q <= res_d.next_state;
			end
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q  <= '0;
			rnd_q  <= pop_cmd.value;
			base_q <= started_q ? ADDR_W'(cur_state_q) * ADDR_W'(MAX_STATES)
			                    : ADDR_W'(INIT_BASE);
		end else if (data_v_q) begin
			sum_q <= sum_sat;
		end
		if (rd_en) begin
			acc_idx_q <= iss_q[IDX_W-1:0];
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pop_cmd.addr] <= pop_cmd.value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/markov_chain_state_sampler.sv =====
`default_nettype none
// A word is registered in the front end and queued before the back end retires it;
// a step result follows its walk, which entry k ends (k < MAX_STATES); num_states 0 skips it.
// Throughput: writes and restarts 1 word/cycle while no step walks and the queue has room;
// a step holds the back end for its walk and waits for the last result to drain.
// Reset: arst_n clears the state to 0, the chain to not started and num_states to 16;
// the probability tables are undefined until written and get no clearing pass.
module markov_chain_state_sampler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // row[3:0], column[7:4], probability[23:8],
	                                // random_fraction[39:24]
	input  logic [1:0]   s_tuser,   // operation[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // next_state[3:0], from_initial[4], found[5], zero[7:6]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data   // num_states
);
	import mcss_pkg::*;

	logic [CFG_W-1:0]  num_states_q;
	logic              push;
	cmd_t              push_cmd;
	logic              push_ready;
	logic              pop_valid;
	cmd_t              pop_cmd;
	logic              pop;
	result_t           result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= CFG_W'(MAX_STATES);
		end else if (cfg_valid && cfg_ready) begin
			num_states_q <= cfg_data;
		end
	end

	mcss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	mcss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop)
	);

	mcss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_states (num_states_q),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_result   (result)
	);

	assign m_tdata = {2'b00, result.found, result.from_initial, result.next_state};

endmodule
`default_nettype wire

// ===== sim/markov_step_checker.sv =====
`timescale 1ns / 1ps
module markov_step_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,    // row[3:0], column[7:4], probability[23:8],
	                                // random_fraction[39:24]
	input  logic [1:0]  s_tuser,    // operation[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,    // next_state[3:0], from_initial[4], found[5], zero[7:6]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,   // num_states
	output int          draws_pending,
	output int          mismatches
);
	import mcss_pkg::*;

	logic [PROB_BITS-1:0] init_prob [MAX_STATES];
	logic [PROB_BITS-1:0] trans_prob [MAX_STATES][MAX_STATES];
	logic [IDX_W-1:0]     chain_state;
	logic                 chain_live;
	logic [CFG_W-1:0]     walk_len;
	result_t              expected_draws [$];
	result_t              want;
	int                   errs = 0;

	assign mismatches = errs;

	task automatic report(input string what, input int got, input int exp_val);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
		errs++;
	endtask

	// Inverse-CDF walk over one row; returns 1 and the index once the sum passes frac.
	function automatic logic draw_from_row(input logic from_init, input logic [IDX_W-1:0] src,
	                                       input logic [PROB_BITS-1:0] frac,
	                                       output logic [IDX_W-1:0] pick);
		logic [SUM_BITS:0]    acc;
		logic [PROB_BITS-1:0] p;
		int                   n;
		acc  = '0;
		pick = '0;
		n    = (walk_len > MAX_STATES) ? MAX_STATES : int'(walk_len);
		for (int i = 0; i < n; i++) begin
			p   = from_init ? init_prob[i] : trans_prob[src][i];
			acc = acc + p;
			if (acc > {1'b0, {SUM_BITS{1'b1}}}) begin
				acc = {1'b0, {SUM_BITS{1'b1}}};
			end
			if (acc > frac) begin
				pick = IDX_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic take_word(input op_t op, input logic [39:0] word);
		logic [IDX_W-1:0] pick;
		logic             hit;
		result_t          r;
		case (op)
			OP_WRITE_INIT: begin
				init_prob[word[7:4]] = word[23:8];
			end
			OP_WRITE_MATRIX: begin
				trans_prob[word[3:0]][word[7:4]] = word[23:8];
			end
			OP_RESTART: begin
				chain_live = 1'b0;
			end
			OP_STEP: begin
				hit        = draw_from_row(!chain_live, chain_state, word[39:24], pick);
				r.from_initial = !chain_live;
				chain_live = 1'b1;
				if (hit) begin
					chain_state = pick;
				end
				r.next_state = chain_state;
				r.found      = hit;
				expected_draws.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_state = '0;
			chain_live  = 1'b0;
			walk_len    = CFG_W'(MAX_STATES);
			expected_draws.delete();
			draws_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				walk_len = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				take_word(op_t'(s_tuser), s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (expected_draws.size() == 0) begin
					report("result word with nothing expected", int'(m_tdata), 0);
				end else begin
					want = expected_draws.pop_front();
					if (m_tdata[3:0] != want.next_state)
						report("next_state", int'(m_tdata[3:0]), int'(want.next_state));
					if (m_tdata[4] != want.from_initial)
						report("from_initial", int'(m_tdata[4]), int'(want.from_initial));
					if (m_tdata[5] != want.found)
						report("found", int'(m_tdata[5]), int'(want.found));
					if (m_tdata[7:6] != 2'b00)
						report("padding bits", int'(m_tdata[7:6]), 0);
				end
			end
			draws_pending <= expected_draws.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import mcss_pkg::*;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // row[3:0], column[7:4], probability[23:8],
	                               // random_fraction[39:24]
	logic [1:0]  s_tuser   = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // next_state[3:0], from_initial[4], found[5], zero[7:6]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data  = '0;   // num_states

	int draws_pending;
	int mismatches;
	int src_idle_pct  = 18;
	int sink_idle_pct = 64;
	int words_sent    = 0;
	int num_cfg       = MAX_STATES;

	markov_chain_state_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	markov_step_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.draws_pending (draws_pending),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Entered right after a rising edge; returns at the edge that takes the word.
	task automatic send_word(input op_t op, input logic [3:0] r, input logic [3:0] c,
	                         input logic [15:0] p, input logic [15:0] f);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {f, p, c, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic write_init(input int c, input int p);
		send_word(OP_WRITE_INIT, 4'($urandom_range(0, 15)), 4'(c), 16'(p),
		          16'($urandom_range(0, 65535)));
	endtask

	task automatic write_trans(input int r, input int c, input int p);
		send_word(OP_WRITE_MATRIX, 4'(r), 4'(c), 16'(p), 16'($urandom_range(0, 65535)));
	endtask

	task automatic take_step(input int f);
		send_word(OP_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
		          16'($urandom_range(0, 65535)), 16'(f));
	endtask

	task automatic restart_chain();
		send_word(OP_RESTART, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
		          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
	endtask

	// Drop valid, wait out every pending draw, then the longest write/restart tail.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (draws_pending != 0) @(posedge clk);
		repeat (MAX_STATES + 6) @(posedge clk);
	endtask

	task automatic set_states(input int v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= 5'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		num_cfg = v;
	endtask

	// Load one row as a rough distribution; row MAX_STATES means the initial table.
	task automatic load_row(input int tgt, input int width);
		int ceiling;
		int v;
		int k;
		ceiling = (65536 * $urandom_range(2, 5)) / (2 * width);
		if (ceiling > 65535) ceiling = 65535;
		for (int c = 0; c < width; c++) begin
			v = $urandom_range(0, ceiling);
			k = $urandom_range(0, 39);
			if (k < 4) v = 0;
			else if (k == 4) v = 65535;
			if (tgt == MAX_STATES) write_init(c, v);
			else write_trans(tgt, c, v);
		end
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		int kind;
		int width;
		stop_at = words_sent + count;
		width   = (num_cfg == 0 || num_cfg > MAX_STATES) ? MAX_STATES : num_cfg;
		while (words_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				load_row($urandom_range(0, MAX_STATES), width);
				repeat ($urandom_range(1, 4)) take_step($urandom_range(0, 65535));
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 6)) take_step($urandom_range(0, 65535));
			end else if (kind < 82) begin
				restart_chain();
				take_step($urandom_range(0, 65535));
			end else if (kind < 95) begin
				if ($urandom_range(0, 1)) write_init($urandom_range(0, 15), $urandom_range(0, 65535));
				else write_trans($urandom_range(0, 15), $urandom_range(0, 15),
				                 $urandom_range(0, 65535));
			end else begin
				// hold the stream until the chain has answered everything
				wait_idle();
				take_step($urandom_range(0, 65535));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		set_states(MAX_STATES);

		// every table entry gets a value before any walk can read it
		for (int r = 0; r <= MAX_STATES; r++) load_row(r, MAX_STATES);

		// one-entry walks: empty row, exact-boundary fraction, restarts
		set_states(1);
		write_init(0, 0);
		take_step(0);
		take_step(65535);
		write_trans(0, 0, 65535);
		take_step(65535);
		take_step(65534);
		restart_chain();
		restart_chain();
		write_init(0, 65535);
		take_step(0);
		take_step(0);

		// zero-length walk never finds a state
		set_states(0);
		take_step(0);
		restart_chain();
		take_step(65535);

		set_states(MAX_STATES);
		write_init(15, 65535);
		write_trans(15, 15, 65535);
		take_step(65535);
		take_step(0);

		// oversized setting clamps the walk
		set_states(31);
		take_step($urandom_range(0, 65535));
		take_step($urandom_range(0, 65535));

		set_states(MAX_STATES);
		random_phase(240);

		src_idle_pct  = 64;
		sink_idle_pct = 18;
		set_states($urandom_range(2, 15));
		random_phase(240);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		set_states($urandom_range(1, 16));
		random_phase(240);

		wait_idle();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
